/* rtl/core/rmg_pkg.sv */
// Shared types and constants of the lathe mesh generator.
package rmg_pkg;

  // Sizes of the profile store, the instance range and the sine table
  localparam int unsigned MAX_INSTANCES    = 256;
  localparam int unsigned MAX_PROFILE      = 256;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned COORD_WIDTH      = 16;

  localparam int unsigned PROF_AW  = $clog2(MAX_PROFILE);
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned IDX_W    = 17;
  localparam int unsigned TAB_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QS_W     = 15;
  localparam int unsigned TRIG_W   = 16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]      trig_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Rotation axis; the fourth code turns rotation and reversal off
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    CFG_INSTANCE_COUNT = 3'd0,
    CFG_PROFILE_LENGTH = 3'd1,
    CFG_AXIS           = 3'd2,
    CFG_SEAM_COPY      = 3'd3,
    CFG_PHASE_STEP     = 3'd4
  } cfg_idx_e;

  // Control that travels with an item into the rotation unit
  typedef struct packed {
    axis_e axis;
    logic  rotate;
  } rot_ctl_t;

endpackage

/* rtl/core/revolution_mesh_generator.sv */
// Lathe mesh generator top level: config, item control, store and output register.
//
// Input channel (in_valid_i / in_stall_o): cmd_i 0 loads point_*_i into the profile
// at profile_index_i; cmd_i 1 emits the vertex of profile position profile_index_i
// on instance instance_index_i. Every item, load or emit, returns one result on the
// output channel (out_valid_o / out_stall_i): status, rotated vertex, vertex index
// and the corner b of the quad that starts there.
// The user must write configuration through cfg_we_i / cfg_index_i / cfg_data_i only
// while idle; the block does not enforce it. The transfer edge registers the store
// read and the phase, then come the table lookup, the products, and round and
// saturate into the result register, where out_valid_o rises. One item is in flight
// at a time: in_stall_o is high from the transfer until the result is taken.
// Receiver stall holds the result register and keeps the input stalled.
// Reset clears the config registers to their defaults, the axis captures to zero
// and the pipeline to empty; the profile store holds garbage until loaded.
module revolution_mesh_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [8:0]                instance_index_i,
  input  logic [7:0]                profile_index_i,
  input  rmg_pkg::coord_t           point_x_i,
  input  rmg_pkg::coord_t           point_y_i,
  input  rmg_pkg::coord_t           point_z_i,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [15:0]               cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      status_o,
  output rmg_pkg::coord_t           vertex_x_o,
  output rmg_pkg::coord_t           vertex_y_o,
  output rmg_pkg::coord_t           vertex_z_o,
  output logic [16:0]               vertex_index_o,
  output logic                      quad_valid_o,
  output logic [16:0]               corner_b_o
);
  import rmg_pkg::*;

  typedef struct packed {
    logic       emit_ok;
    logic       status;
    logic       quad;
    logic       rotate;
    logic [7:0] pos;
  } item_ctl_t;

  // Configuration registers
  logic [CNT_W-1:0] inst_cnt_q;
  logic [CNT_W-1:0] prof_len_q;
  axis_e            axis_q;
  logic             seam_q;
  logic [15:0]      phase_step_q;

  coord_t           first_q;
  coord_t           last_q;

  logic             busy_q;
  logic [2:0]       stg_q;
  logic             out_valid_q;
  item_ctl_t        ctl_q;
  item_ctl_t        ctl_d;
  logic [17:0]      li_q;
  logic [17:0]      ln_q;

  logic             status_q;
  point_t           vtx_q;
  logic [IDX_W-1:0] vidx_q;
  logic             quad_q;
  logic [IDX_W-1:0] cornb_q;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] l_eff;
  logic [CNT_W-1:0] l_m1;
  logic [CNT_W-1:0] pos_w;
  logic [CNT_W-1:0] src;
  logic [CNT_W:0]   inst_p1;
  logic [CNT_W-1:0] nxt;
  logic             in_acc;
  logic             out_xfer;
  logic             axis_ok;
  logic             load_ok;
  logic             inst_lt;
  logic             inst_seam;
  logic             pos_ok;
  logic             rev;
  logic             store_we;
  coord_t           axis_coord;
  point_t           wr_pt;
  point_t           rd_pt;
  point_t           rot_pt;
  trig_t            sin_v;
  trig_t            cos_v;
  rot_ctl_t         rctl;

  assign in_acc   = in_valid_i & ~busy_q;
  assign out_xfer = out_valid_q & ~out_stall_i;

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_cnt_q   <= CNT_W'(16);
      prof_len_q   <= CNT_W'(2);
      axis_q       <= AXIS_Y;
      seam_q       <= 1'b0;
      phase_step_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INSTANCE_COUNT: inst_cnt_q   <= cfg_data_i[CNT_W-1:0];
        CFG_PROFILE_LENGTH: prof_len_q   <= cfg_data_i[CNT_W-1:0];
        CFG_AXIS:           axis_q       <= axis_e'(cfg_data_i[1:0]);
        CFG_SEAM_COPY:      seam_q       <= cfg_data_i[0];
        CFG_PHASE_STEP:     phase_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp counts and decode the incoming item
  always_comb begin
    n_eff = (inst_cnt_q > CNT_W'(MAX_INSTANCES)) ? CNT_W'(MAX_INSTANCES) : inst_cnt_q;
    l_eff = (prof_len_q > CNT_W'(MAX_PROFILE)) ? CNT_W'(MAX_PROFILE) : prof_len_q;
    l_m1  = l_eff - 1'b1;
    pos_w = {1'b0, profile_index_i};

    axis_ok   = (axis_q == AXIS_X) || (axis_q == AXIS_Y) || (axis_q == AXIS_Z);
    load_ok   = pos_w < CNT_W'(MAX_PROFILE);
    inst_lt   = instance_index_i < n_eff;
    inst_seam = seam_q && (n_eff != '0) && (instance_index_i == n_eff);
    pos_ok    = pos_w < l_eff;
    rev       = axis_ok && (first_q > last_q);
    src       = rev ? (l_m1 - pos_w) : pos_w;

    // Next instance for corner b: wrap unless the seam copy exists
    inst_p1 = {1'b0, instance_index_i} + 1'b1;
    if (seam_q) begin
      nxt = inst_p1[CNT_W-1:0];
    end else if (inst_p1 == {1'b0, n_eff}) begin
      nxt = '0;
    end else begin
      nxt = inst_p1[CNT_W-1:0];
    end

    ctl_d.emit_ok = cmd_i & (inst_lt | inst_seam) & pos_ok;
    ctl_d.status  = cmd_i ? ~ctl_d.emit_ok : ~load_ok;
    ctl_d.quad    = inst_lt && ((pos_w + 1'b1) < l_eff);
    ctl_d.rotate  = inst_lt && axis_ok;
    ctl_d.pos     = profile_index_i;

    case (axis_q)
      AXIS_X:  axis_coord = point_x_i;
      AXIS_Y:  axis_coord = point_y_i;
      AXIS_Z:  axis_coord = point_z_i;
      default: axis_coord = '0;
    endcase
  end

  assign store_we = in_acc & ~cmd_i & load_ok;
  assign wr_pt    = '{x: point_x_i, y: point_y_i, z: point_z_i};

  // Capture the axis coordinates of the profile ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
    end else if (store_we) begin
      if (pos_w == '0) begin
        first_q <= axis_coord;
      end
      if ((l_eff != '0) && (pos_w == l_m1)) begin
        last_q <= axis_coord;
      end
    end
  end

  // Hold item control and the index products for the whole item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctl_q <= ctl_d;
      li_q  <= l_eff * instance_index_i;
      ln_q  <= l_eff * nxt;
    end
  end

  // Advance the item token and track the one item in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stg_q <= {stg_q[1:0], in_acc};
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_xfer) begin
        busy_q <= 1'b0;
      end
      if (stg_q[2]) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  rmg_profile_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (profile_index_i[PROF_AW-1:0]),
    .wdata_i (wr_pt),
    .re_i    (in_acc),
    .raddr_i (src[PROF_AW-1:0]),
    .rdata_o (rd_pt)
  );

  rmg_trig u_trig (
    .clk_i        (clk_i),
    .load_i       (in_acc),
    .instance_i   (instance_index_i),
    .phase_step_i (phase_step_q),
    .sin_o        (sin_v),
    .cos_o        (cos_v)
  );

  assign rctl = '{axis: axis_q, rotate: ctl_q.rotate};

  rmg_rotate u_rot (
    .clk_i   (clk_i),
    .ctl_i   (rctl),
    .point_i (rd_pt),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .point_o (rot_pt)
  );

  // Load the result register when the item leaves the last stage
  always_ff @(posedge clk_i) begin
    if (stg_q[2]) begin
      status_q <= ctl_q.status;
      if (ctl_q.emit_ok) begin
        vtx_q   <= rot_pt;
        vidx_q  <= IDX_W'(li_q + 18'(ctl_q.pos));
        quad_q  <= ctl_q.quad;
        cornb_q <= ctl_q.quad ? IDX_W'(ln_q + 18'(ctl_q.pos)) : '0;
      end else begin
        vtx_q   <= '0;
        vidx_q  <= '0;
        quad_q  <= 1'b0;
        cornb_q <= '0;
      end
    end
  end

  assign in_stall_o     = busy_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign vertex_x_o     = vtx_q.x;
  assign vertex_y_o     = vtx_q.y;
  assign vertex_z_o     = vtx_q.z;
  assign vertex_index_o = vidx_q;
  assign quad_valid_o   = quad_q;
  assign corner_b_o     = cornb_q;

endmodule

/* rtl/core/rmg_profile_mem.sv */
// Profile point store: one write port, one registered read port.
module rmg_profile_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rmg_pkg::PROF_AW-1:0]   waddr_i,
  input  rmg_pkg::point_t               wdata_i,
  input  logic                          re_i,
  input  logic [rmg_pkg::PROF_AW-1:0]   raddr_i,
  output rmg_pkg::point_t               rdata_o
);
  import rmg_pkg::*;

  point_t mem [MAX_PROFILE];
  point_t rdata_q;

  // Write a loaded point
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read on accept and hold the point until the next accept
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rmg_trig.sv */
// Phase multiply and quarter-wave sine/cosine lookup, two register stages.
module rmg_trig (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [rmg_pkg::CNT_W-1:0]   instance_i,
  input  logic [15:0]                 phase_step_i,
  output rmg_pkg::trig_t              sin_o,
  output rmg_pkg::trig_t              cos_o
);
  import rmg_pkg::*;

  localparam int unsigned QTR  = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QIW  = TAB_BITS - 2;
  localparam int unsigned STEP = 65536 / SINE_TABLE_DEPTH;

  // Polynomial quarter sine in Q1.14, evaluated at elaboration only
  function automatic logic [QS_W-1:0] qs(input int unsigned xin);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned u;
    longint unsigned r;
    x  = longint'(xin);
    x2 = (x * x) >> 14;
    t  = (64'd1160 * x2) >> 14;
    u  = (x2 * (64'd10512 - t)) >> 14;
    r  = (x * (64'd25736 - u)) >> 14;
    return r[QS_W-1:0];
  endfunction

  localparam logic [QS_W-1:0] QS_PEAK = qs(16384);

  logic [15:0]         ang_q;
  logic [QS_W-1:0]     qtab [QTR];
  logic [TAB_BITS-1:0] kk   [2];
  trig_t               val  [2];
  trig_t               sin_q;
  trig_t               cos_q;

  // Constant quarter-wave table
  for (genvar g = 0; g < QTR; g++) begin : g_tab
    assign qtab[g] = qs(g * STEP);
  end

  // Register the instance phase
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ang_q <= 16'(instance_i * phase_step_i);
    end
  end

  // Sine lane uses the table entry, cosine lane is a quarter turn ahead
  assign kk[0] = ang_q[15 -: TAB_BITS];
  assign kk[1] = kk[0] + TAB_BITS'(QTR);

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_comb begin
      logic [1:0]      quad;
      logic [QIW-1:0]  f;
      logic [QIW-1:0]  fneg;
      logic [QS_W-1:0] mag;
      quad = kk[l][TAB_BITS-1 -: 2];
      f    = kk[l][QIW-1:0];
      fneg = ~f + 1'b1;
      // Mirror in odd quadrants; the peak sits one past the table end
      if (quad[0]) begin
        mag = (f == '0) ? QS_PEAK : qtab[fneg];
      end else begin
        mag = qtab[f];
      end
      if (quad[1]) begin
        val[l] = trig_t'(0) - $signed({1'b0, mag});
      end else begin
        val[l] = $signed({1'b0, mag});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= val[0];
    cos_q <= val[1];
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* rtl/core/rmg_rotate.sv */
// Rotation of a point about one axis: registered products, then round and saturate.
module rmg_rotate (
  input  logic              clk_i,
  input  rmg_pkg::rot_ctl_t ctl_i,
  input  rmg_pkg::point_t   point_i,
  input  rmg_pkg::trig_t    sin_i,
  input  rmg_pkg::trig_t    cos_i,
  output rmg_pkg::point_t   point_o
);
  import rmg_pkg::*;

  // Round a Q1.14 by Q8.8 sum to nearest and clamp to the coordinate range
  function automatic coord_t round_sat(input logic signed [32:0] v);
    logic signed [33:0] r;
    logic signed [19:0] sh;
    logic               fits;
    r    = 34'(v) + 34'sd8192;
    sh   = 20'(r >>> 14);
    fits = (sh[19:COORD_WIDTH-1] == '0) || (sh[19:COORD_WIDTH-1] == '1);
    if (fits) begin
      return sh[COORD_WIDTH-1:0];
    end else if (sh[19]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  coord_t                   u;
  coord_t                   v;
  logic signed [31:0]       cu_q, sv_q, su_q, cv_q;
  rot_ctl_t                 ctl_q;
  point_t                   pt_q;
  logic signed [32:0]       du;
  logic signed [32:0]       dv;
  coord_t                   ru;
  coord_t                   rv;

  // Pick the rotating pair: u' = c*u - s*v, v' = s*u + c*v
  always_comb begin
    case (ctl_i.axis)
      AXIS_X: begin
        u = point_i.y;
        v = point_i.z;
      end
      AXIS_Y: begin
        u = point_i.z;
        v = point_i.x;
      end
      default: begin
        u = point_i.x;
        v = point_i.y;
      end
    endcase
  end

  // Register the four products
  always_ff @(posedge clk_i) begin
    cu_q  <= cos_i * u;
    sv_q  <= sin_i * v;
    su_q  <= sin_i * u;
    cv_q  <= cos_i * v;
    ctl_q <= ctl_i;
    pt_q  <= point_i;
  end

  assign du = 33'(cu_q) - 33'(sv_q);
  assign dv = 33'(su_q) + 33'(cv_q);
  assign ru = round_sat(du);
  assign rv = round_sat(dv);

  // Put the rotated pair back in place, or pass the point through
  always_comb begin
    point_o = pt_q;
    if (ctl_q.rotate) begin
      case (ctl_q.axis)
        AXIS_X: begin
          point_o.y = ru;
          point_o.z = rv;
        end
        AXIS_Y: begin
          point_o.z = ru;
          point_o.x = rv;
        end
        default: begin
          point_o.x = ru;
          point_o.y = rv;
        end
      endcase
    end
  end

endmodule

/* sim/tb_revolution_mesh_generator.sv */
// Testbench of the lathe mesh generator: directed and random profile loads and mesh emits.
module tb_revolution_mesh_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import rmg_pkg::*;

  localparam logic       CMD_LOAD        = 1'b0;
  localparam logic       CMD_EMIT        = 1'b1;
  localparam logic       STATUS_RANGE    = 1'b1;
  // Fourth axis code: no rotation, no reversal
  localparam logic [1:0] AXIS_OFF        = 2'd3;
  localparam int         RAND_PHASES     = 4;
  localparam int         EMITS_PER_PHASE = 40;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         MAX_GAP         = 12;
  localparam int         MAX_REPORTS     = 40;
  localparam int         TIMEOUT_NS      = 5_000_000;
  localparam longint     SAT_HI          = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint     SAT_LO          = -SAT_HI - 1;

  typedef struct packed {
    logic       cmd;
    logic [8:0] inst;
    logic [7:0] pos;
    coord_t     px;
    coord_t     py;
    coord_t     pz;
  } mesh_item_t;

  typedef struct packed {
    logic             status;
    coord_t           vx;
    coord_t           vy;
    coord_t           vz;
    logic [IDX_W-1:0] vidx;
    logic             quad;
    logic [IDX_W-1:0] cb;
  } mesh_result_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic                cmd_i            = 1'b0;
  logic [8:0]          instance_index_i = '0;
  logic [7:0]          profile_index_i  = '0;
  coord_t              point_x_i        = '0;
  coord_t              point_y_i        = '0;
  coord_t              point_z_i        = '0;
  logic                cfg_we_i         = 1'b0;
  logic [2:0]          cfg_index_i      = '0;
  logic [15:0]         cfg_data_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                status_o;
  coord_t              vertex_x_o;
  coord_t              vertex_y_o;
  coord_t              vertex_z_o;
  logic [16:0]         vertex_index_o;
  logic                quad_valid_o;
  logic [16:0]         corner_b_o;

  // Predictor state: register copies at their reset values, profile and axis captures
  logic [CNT_W-1:0]    cfg_count = 9'd16;
  logic [CNT_W-1:0]    cfg_len   = 9'd2;
  logic [1:0]          cfg_axis  = AXIS_Y;
  logic                cfg_seam  = 1'b0;
  logic [15:0]         cfg_phase = 16'd4096;
  point_t              profile_copy [MAX_PROFILE];
  bit                  loaded_pos   [MAX_PROFILE];
  coord_t              first_axis   = '0;
  coord_t              last_axis    = '0;

  mesh_result_t        pending_vertices [$];

  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  err_count   = 0;
  int                  n_loads     = 0;
  int                  n_emits     = 0;
  int                  n_flagged   = 0;
  int                  n_checked   = 0;
  int                  n_settings  = 0;

  revolution_mesh_generator u_top (.*);

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Polynomial quarter sine in Q1.14
  function automatic longint quarter_wave(longint unsigned x);
    longint unsigned x2, t, u;
    x2 = (x * x) >> 14;
    t  = (64'd1160 * x2) >> 14;
    u  = (x2 * (64'd10512 - t)) >> 14;
    return longint'((x * (64'd25736 - u)) >> 14);
  endfunction

  // Full-turn sine from the quadrant and the offset inside it
  function automatic longint sine_q14(logic [15:0] ph);
    longint unsigned f;
    longint          r;
    f = ph[13:0];
    r = ph[14] ? quarter_wave(64'd16384 - f) : quarter_wave(f);
    return ph[15] ? -r : r;
  endfunction

  // Round a Q1.14 by Q8.8 product sum back to Q8.8 and saturate
  function automatic coord_t rotate_pair(longint ca, longint a, longint cb, longint b);
    longint v;
    v = (ca * a + cb * b + 8192) >>> 14;
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return coord_t'(v);
  endfunction

  function automatic int unsigned eff_length();
    return (cfg_len > MAX_PROFILE) ? MAX_PROFILE : cfg_len;
  endfunction

  function automatic int unsigned eff_count();
    return (cfg_count > MAX_INSTANCES) ? MAX_INSTANCES : cfg_count;
  endfunction

  function automatic coord_t axis_coord(point_t p);
    case (cfg_axis)
      AXIS_X:  return p.x;
      AXIS_Y:  return p.y;
      AXIS_Z:  return p.z;
      default: return '0;
    endcase
  endfunction

  function automatic bit emit_valid(mesh_item_t it);
    int unsigned cnt;
    cnt = eff_count();
    return (it.inst < cnt || (cfg_seam && cnt >= 1 && it.inst == cnt)) &&
           it.pos < eff_length();
  endfunction

  // Stored position read for an emitted position, reversed when the profile runs downward
  function automatic int unsigned source_pos(logic [7:0] pos);
    if (cfg_axis != AXIS_OFF && first_axis > last_axis) return eff_length() - 1 - pos;
    return pos;
  endfunction

  // Apply one item to the predictor state and return the vertex it yields
  function automatic mesh_result_t predict_mesh(mesh_item_t it);
    mesh_result_t r;
    int unsigned  len, cnt, nxt, ang, ti;
    logic [15:0]  ph;
    longint       s, c, x, y, z;
    point_t       p;
    r   = '0;
    len = eff_length();
    cnt = eff_count();
    if (it.cmd == CMD_LOAD) begin
      p = {it.px, it.py, it.pz};
      profile_copy[it.pos] = p;
      loaded_pos[it.pos]   = 1'b1;
      if (it.pos == 0) first_axis = axis_coord(p);
      if (len >= 1 && it.pos == len - 1) last_axis = axis_coord(p);
      return r;
    end
    if (!emit_valid(it)) begin
      r.status = STATUS_RANGE;
      return r;
    end
    p    = profile_copy[source_pos(it.pos)];
    x    = p.x;
    y    = p.y;
    z    = p.z;
    r.vx = p.x;
    r.vy = p.y;
    r.vz = p.z;
    // Rotate every instance but the seam copy, and none while the axis is off
    if (it.inst < cnt && cfg_axis != AXIS_OFF) begin
      ang = (it.inst * cfg_phase) & 32'hFFFF;
      ti  = (ang * SINE_TABLE_DEPTH) >> 16;
      ph  = 16'((ti << 16) / SINE_TABLE_DEPTH);
      s   = sine_q14(ph);
      c   = sine_q14(ph + 16'd16384);
      case (cfg_axis)
        AXIS_Y: begin
          r.vx = rotate_pair(c, x, s, z);
          r.vz = rotate_pair(-s, x, c, z);
        end
        AXIS_X: begin
          r.vy = rotate_pair(c, y, -s, z);
          r.vz = rotate_pair(s, y, c, z);
        end
        AXIS_Z: begin
          r.vx = rotate_pair(c, x, -s, y);
          r.vy = rotate_pair(s, x, c, y);
        end
        default: ;
      endcase
    end
    r.vidx = IDX_W'(len * it.inst + it.pos);
    // Quad to the next instance; wrap to instance 0 unless the seam row exists
    if (it.inst < cnt && it.pos + 1 < len) begin
      nxt    = cfg_seam ? it.inst + 1 : (it.inst + 1) % cnt;
      r.quad = 1'b1;
      r.cb   = IDX_W'(len * nxt + it.pos);
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return coord_t'(SAT_HI);
      1:       return coord_t'(SAT_LO);
      2:       return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic mesh_item_t load_item(logic [7:0] pos, coord_t x, coord_t y, coord_t z);
    mesh_item_t it;
    it.cmd  = CMD_LOAD;
    it.inst = 9'($urandom);
    it.pos  = pos;
    it.px   = x;
    it.py   = y;
    it.pz   = z;
    return it;
  endfunction

  function automatic mesh_item_t emit_item(logic [8:0] inst, logic [7:0] pos);
    mesh_item_t it;
    it.cmd  = CMD_EMIT;
    it.inst = inst;
    it.pos  = pos;
    it.px   = rand_coord();
    it.py   = rand_coord();
    it.pz   = rand_coord();
    return it;
  endfunction

  // Mostly in-range emits, some profile rewrites, the rest raw noise
  function automatic mesh_item_t random_item();
    mesh_item_t  it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      it = emit_item(9'($urandom_range(eff_count())), 8'($urandom_range(eff_length() - 1)));
    end else if (pick < 85) begin
      it = load_item(8'($urandom_range(eff_length() - 1)), rand_coord(), rand_coord(),
                     rand_coord());
    end else begin
      it.cmd  = 1'($urandom);
      it.inst = 9'($urandom);
      it.pos  = 8'($urandom);
      it.px   = coord_t'($urandom);
      it.py   = coord_t'($urandom);
      it.pz   = coord_t'($urandom);
    end
    // Load a never-written entry instead of reading it
    if (it.cmd == CMD_EMIT && emit_valid(it) && !loaded_pos[source_pos(it.pos)])
      it = load_item(8'(source_pos(it.pos)), rand_coord(), rand_coord(), rand_coord());
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic signed [63:0] got, logic signed [63:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  // Compare one transferred result against the oldest prediction
  task automatic check_mesh_result();
    mesh_result_t e;
    if (pending_vertices.size() == 0) begin
      report_mismatch("result transfer with no prediction waiting");
      return;
    end
    e = pending_vertices.pop_front();
    n_checked++;
    compare_field("status", status_o, e.status);
    compare_field("vertex_x", vertex_x_o, e.vx);
    compare_field("vertex_y", vertex_y_o, e.vy);
    compare_field("vertex_z", vertex_z_o, e.vz);
    compare_field("vertex_index", vertex_index_o, e.vidx);
    compare_field("quad_valid", quad_valid_o, e.quad);
    compare_field("corner_b", corner_b_o, e.cb);
  endtask

  // Take results and stall the output at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_mesh_result();
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Present one item, hold it until transferred, then maybe idle for a while
  task automatic send_item(mesh_item_t it);
    mesh_result_t r;
    cmd_i            <= it.cmd;
    instance_index_i <= it.inst;
    profile_index_i  <= it.pos;
    point_x_i        <= it.px;
    point_y_i        <= it.py;
    point_z_i        <= it.pz;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_mesh(it);
    pending_vertices = {pending_vertices, r};
    if (it.cmd == CMD_EMIT) n_emits++;
    else n_loads++;
    if (r.status == STATUS_RANGE) n_flagged++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
  endtask

  // Drain every outstanding result, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_INSTANCE_COUNT: cfg_count = val[CNT_W-1:0];
      CFG_PROFILE_LENGTH: cfg_len   = val[CNT_W-1:0];
      CFG_AXIS:           cfg_axis  = val[1:0];
      CFG_SEAM_COPY:      cfg_seam  = val[0];
      CFG_PHASE_STEP:     cfg_phase = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_settings(logic [15:0] cnt, logic [15:0] len, logic [1:0] ax,
                                logic seam, logic [15:0] ph);
    wait_idle();
    cfg_we_i <= 1'b1;
    write_reg(CFG_INSTANCE_COUNT, cnt);
    write_reg(CFG_PROFILE_LENGTH, len);
    write_reg(CFG_AXIS, ax);
    write_reg(CFG_SEAM_COPY, seam);
    write_reg(CFG_PHASE_STEP, ph);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Reset settings: 16 instances, two points, Y axis, no seam
  task automatic test_reset_defaults();
    send_item(load_item(8'd0, 1280, -768, 0));
    send_item(load_item(8'd1, -2560, 3000, 640));
    send_item(emit_item(9'd15, 8'd0));
    send_item(emit_item(9'd16, 8'd1));
  endtask

  // Full-scale coordinates at 45 degrees, wrap quad, last row, bad indices
  task automatic test_extremes();
    write_settings(16'd8, 16'd4, AXIS_Y, 1'b0, 16'd8192);
    send_item(load_item(8'd0, SAT_HI, SAT_LO, SAT_HI));
    send_item(load_item(8'd1, SAT_LO, SAT_HI, SAT_LO));
    send_item(load_item(8'd2, 256, 512, -256));
    send_item(load_item(8'd3, 0, SAT_HI, 0));
    send_item(emit_item(9'd1, 8'd0));
    send_item(emit_item(9'd1, 8'd1));
    send_item(emit_item(9'd7, 8'd2));
    send_item(emit_item(9'd0, 8'd3));
    send_item(emit_item(9'd8, 8'd0));
    send_item(emit_item(9'd3, 8'd4));
    send_item(emit_item(9'd511, 8'd255));
  endtask

  // Downward profile on X is read reversed; seam row closes the mesh
  task automatic test_seam_reversal();
    write_settings(16'd4, 16'd3, AXIS_X, 1'b1, 16'd16384);
    send_item(load_item(8'd0, 100, 300, -200));
    send_item(load_item(8'd1, -512, 1000, 2000));
    send_item(load_item(8'd2, -100, -300, SAT_HI));
    send_item(emit_item(9'd4, 8'd0));
    send_item(emit_item(9'd3, 8'd1));
    send_item(emit_item(9'd1, 8'd2));
  endtask

  // Counts above the maxima clamp to them
  task automatic test_oversized_regs();
    write_settings(16'd511, 16'd511, AXIS_Z, 1'b0, 16'hFFFF);
    send_item(load_item(8'd0, 1, 2, 3));
    send_item(load_item(8'd255, -1, -2, -3));
    send_item(emit_item(9'd255, 8'd0));
    send_item(emit_item(9'd0, 8'd255));
  endtask

  // Axis code 3: points pass through unrotated
  task automatic test_axis_off();
    write_settings(16'd3, 16'd2, AXIS_OFF, 1'b0, 16'd0);
    send_item(emit_item(9'd1, 8'd0));
    send_item(emit_item(9'd2, 8'd1));
  endtask

  // Random settings; each phase loads a profile and streams the mesh
  task automatic test_random_mesh(bit full_profile);
    logic [15:0] cnt, len, ph;
    logic [1:0]  ax;
    for (int k = 0; k < RAND_PHASES; k++) begin
      case ($urandom_range(5))
        0:       cnt = 16'd1;
        1:       cnt = 16'd256;
        2:       cnt = 16'd511;
        default: cnt = 16'($urandom_range(2, 24));
      endcase
      len = 16'($urandom_range(2, 10));
      if (full_profile && k == 0) begin
        cnt = 16'd256;
        len = 16'd256;
      end
      if (full_profile && k == 1) cnt = 16'd1;
      ax = ($urandom_range(7) == 0) ? AXIS_OFF : 2'($urandom_range(2));
      case ($urandom_range(3))
        0:       ph = 16'($urandom_range(65535));
        1:       ph = $urandom_range(1) ? 16'd0 : 16'hFFFF;
        default: ph = 16'(65536 / ((cnt > MAX_INSTANCES) ? MAX_INSTANCES : cnt));
      endcase
      write_settings(cnt, len, ax, 1'($urandom_range(1)), ph);
      for (int j = 0; j < len; j++)
        send_item(load_item(8'(j), rand_coord(), rand_coord(), rand_coord()));
      repeat (EMITS_PER_PHASE) send_item(random_item());
    end
  endtask

  initial begin
    tx_idle_pct = 17;
    rx_idle_pct = 71;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_seam_reversal();
    test_oversized_regs();
    test_axis_off();
    test_random_mesh(1'b1);
    // Swap the idle rates, then run with no idling at all
    tx_idle_pct = 71;
    rx_idle_pct = 17;
    test_random_mesh(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mesh(1'b0);
    wait_idle();
    $display("Covered %0d loads and %0d emits (%0d out of range) over %0d register settings,",
             n_loads, n_emits, n_flagged, n_settings);
    $display("all axes, seam and reversal; %0d results compared, %0d mismatches.",
             n_checked, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rmg_pkg.sv
rtl/core/rmg_profile_mem.sv
rtl/core/rmg_trig.sv
rtl/core/rmg_rotate.sv
rtl/core/revolution_mesh_generator.sv
sim/tb_revolution_mesh_generator.sv
